>>> src/zdat_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers of the zoned disk access timer.
package zdat_pkg;

  localparam int DEF_MAX_TRACKS   = 65536;
  localparam int DEF_MAX_SURFACES = 16;

  localparam int TIME_W  = 63;
  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 32;
  localparam int DIV_W   = 48;
  localparam int MUL_AW  = 48;
  localparam int MUL_BW  = 32;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int BASE_W  = 49;
  localparam int SECT_W  = 13;
  localparam int SECI_W  = 12;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 40;

  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam logic [DIV_W-1:0]  PS_HALF_MIN = 48'd30000000000000;
  localparam logic [DIV_W-1:0]  PS_MIN      = 48'd60000000000000;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SURF  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_TRK   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_INNER = 3'd2;
  localparam logic [CIDX_W-1:0] REG_OUTER = 3'd3;
  localparam logic [CIDX_W-1:0] REG_RPM   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BYTES = 3'd5;
  localparam logic [CIDX_W-1:0] REG_FIX   = 3'd6;
  localparam logic [CIDX_W-1:0] REG_STEP  = 3'd7;

  // divider operand selects
  localparam logic [2:0] DV_CNT  = 3'd0;
  localparam logic [2:0] DV_BLK  = 3'd1;
  localparam logic [2:0] DV_DIFF = 3'd2;
  localparam logic [2:0] DV_OFF  = 3'd3;
  localparam logic [2:0] DV_HALF = 3'd4;
  localparam logic [2:0] DV_SECT = 3'd5;

  // multiplier operand selects
  localparam logic MS_SEEK = 1'b0;
  localparam logic MS_XFER = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] start_time;
    logic [ADDR_W-1:0] byte_address;
    logic [31:0]       byte_count;
  } zdat_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] finish_time;
    logic              address_ok;
    logic              past_end;
    logic [15:0]       first_track;
    logic [3:0]        first_surface;
    logic [11:0]       first_sector;
  } zdat_out_t;

  typedef struct packed {
    logic [4:0]  surface_count;
    logic [16:0] track_count;
    logic [11:0] inner_track_sectors;
    logic [12:0] outer_track_sectors;
    logic [15:0] spin_rpm;
    logic [16:0] block_bytes;
    logic [39:0] seek_fixed_ps;
    logic [39:0] seek_step_ps;
  } zdat_cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic       div_take;
    logic [2:0] div_sel;
    logic       mul_go;
    logic       mul_take;
    logic       mul_sel;
    logic       walk_adv;
    logic       set_bad;
    logic       clr_total;
    logic       add_fix;
    logic       hop_fix;
    logic       add_half;
    logic       next_trk;
    logic       set_past;
    logic       finish;
  } zdat_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic found;
    logic last_trk;
    logic head_same;
    logic xfer_end;
    logic out_free;
  } zdat_sts_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] sat_prod(input logic [PROD_W-1:0] p);
    return (|p[PROD_W-1:TIME_W]) ? TIME_MAX : p[TIME_W-1:0];
  endfunction

endpackage

>>> src/zdat_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module zdat_div #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic         busy_r;
  logic         done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0] quo_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] dvs_r;
  logic [W+1:0] trial;

  assign trial = {1'b0, rem_r, quo_r[W-1]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!trial[W+1]) begin
          rem_r <= trial[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-2:0], quo_r[W-1]};
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> src/zdat_mul.sv
`timescale 1ns / 1ps
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module zdat_mul #(
  parameter int AW = 48,
  parameter int BW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   a_r;
  logic [AW+BW-1:0] p_r;
  logic [AW:0]     sum;

  assign sum = {1'b0, p_r[AW+BW-1:BW]} + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
        a_r    <= a;
        p_r    <= {{AW{1'b0}}, b};
      end else if (busy_r) begin
        p_r   <= {sum, p_r[BW-1:1]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

>>> src/zdat_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the zoned disk access timer.
module zdat_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [zdat_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [zdat_pkg::CDAT_W-1:0]  cfg_data,
  output zdat_pkg::zdat_cfg_t          cfg
);

  import zdat_pkg::*;

  zdat_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_count       <= 5'd4;
      cfg_r.track_count         <= 17'd1024;
      cfg_r.inner_track_sectors <= 12'd256;
      cfg_r.outer_track_sectors <= 13'd512;
      cfg_r.spin_rpm            <= 16'd7200;
      cfg_r.block_bytes         <= 17'd512;
      cfg_r.seek_fixed_ps       <= 40'd1000000000;
      cfg_r.seek_step_ps        <= 40'd10000000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SURF:  cfg_r.surface_count       <= cfg_data[4:0];
        REG_TRK:   cfg_r.track_count         <= cfg_data[16:0];
        REG_INNER: cfg_r.inner_track_sectors <= cfg_data[11:0];
        REG_OUTER: cfg_r.outer_track_sectors <= cfg_data[12:0];
        REG_RPM:   cfg_r.spin_rpm            <= cfg_data[15:0];
        REG_BYTES: cfg_r.block_bytes         <= cfg_data[16:0];
        REG_FIX:   cfg_r.seek_fixed_ps       <= cfg_data[39:0];
        REG_STEP:  cfg_r.seek_step_ps        <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/zdat_dp.sv
`timescale 1ns / 1ps
// Datapath: operand registers, zone stepping, shared divider and multiplier.
module zdat_dp #(
  parameter int MAX_TRACKS   = zdat_pkg::DEF_MAX_TRACKS,
  parameter int MAX_SURFACES = zdat_pkg::DEF_MAX_SURFACES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  zdat_pkg::zdat_cfg_t cfg,
  input  zdat_pkg::zdat_cmd_t cmd,
  output zdat_pkg::zdat_sts_t sts,
  input  zdat_pkg::zdat_in_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output zdat_pkg::zdat_out_t out_data
);

  import zdat_pkg::*;

  localparam int TW  = $clog2(MAX_TRACKS);
  localparam int ETW = $clog2(MAX_TRACKS + 1);
  localparam int SCW = $clog2(MAX_SURFACES + 1);
  localparam int SIW = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
  localparam int NW  = SECT_W + SCW;
  localparam int AVW = SECT_W + SCW + 1;

  // effective settings
  logic [31:0]     sc_w, tc_w;
  logic [SCW-1:0]  eff_surf;
  logic [ETW-1:0]  eff_tracks, d_trk;
  logic [11:0]     eff_inner, eff_diff;
  logic [12:0]     outer_c;
  logic [15:0]     eff_rpm;
  logic [16:0]     eff_bytes;

  always_comb begin
    sc_w = 32'(cfg.surface_count);
    if (sc_w == 32'd0) sc_w = 32'd1;
    if (sc_w > 32'(MAX_SURFACES)) sc_w = 32'(MAX_SURFACES);
    tc_w = 32'(cfg.track_count);
    if (tc_w < 32'd2) tc_w = 32'd2;
    if (tc_w > 32'(MAX_TRACKS)) tc_w = 32'(MAX_TRACKS);
    eff_surf   = sc_w[SCW-1:0];
    eff_tracks = tc_w[ETW-1:0];
    d_trk      = eff_tracks - ETW'(1);
    eff_inner  = (cfg.inner_track_sectors == 12'd0) ? 12'd1 : cfg.inner_track_sectors;
    outer_c    = (cfg.outer_track_sectors > 13'd4096) ? 13'd4096 : cfg.outer_track_sectors;
    eff_diff   = (outer_c > {1'b0, eff_inner}) ? 12'(outer_c - {1'b0, eff_inner}) : 12'd0;
    eff_rpm    = (cfg.spin_rpm == 16'd0) ? 16'd1 : cfg.spin_rpm;
    eff_bytes  = (cfg.block_bytes == 17'd0) ? 17'd1 : cfg.block_bytes;
  end

  // item registers
  logic [TIME_W-1:0]  start_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [COUNT_W-1:0] count_r;
  logic [11:0]        qd_r, q_r;
  logic [ETW-1:0]     rd_r, rem_r;
  logic [TW-1:0]      trk_r, ftrk_r, head_r;
  logic [BASE_W-1:0]  base_r;
  logic [SECI_W-1:0]  sec_r, fsec_r;
  logic [SIW-1:0]     surf_r, fsurf_r;
  logic [TIME_W-1:0]  half_r, hop_r, total_r;
  logic [DIV_W-1:0]   stime_r;
  logic               ok_r, past_r;
  logic               out_valid_r;
  zdat_out_t          out_r;

  // zone stepping: S(t) = inner + q, q*D + rem = diff*t
  logic [ETW:0]       rs;
  logic               rs_ge;
  logic [ETW-1:0]     rem_n;
  logic [11:0]        q_n;
  logic [SECT_W-1:0]  s_cur;
  logic [NW-1:0]      n_cur;
  logic [BASE_W-1:0]  base_sum;
  logic [ETW-1:0]     trk_p1;
  logic [SECT_W-1:0]  s_left;
  logic [AVW-1:0]     avail;
  logic [COUNT_W-1:0] take;
  logic [TW-1:0]      trk_gap;
  logic [28:0]        rpm_s;
  logic [BASE_W-1:0]  off_w;

  assign rs       = {1'b0, rem_r} + {1'b0, rd_r};
  assign rs_ge    = rs >= {1'b0, d_trk};
  assign rem_n    = rs_ge ? ETW'(rs - {1'b0, d_trk}) : ETW'(rs);
  assign q_n      = q_r + qd_r + (rs_ge ? 12'd1 : 12'd0);
  assign s_cur    = {1'b0, eff_inner} + {1'b0, q_r};
  assign n_cur    = NW'(s_cur) * NW'(eff_surf);
  assign base_sum = base_r + BASE_W'(n_cur);
  assign trk_p1   = ETW'(trk_r) + ETW'(1);
  assign s_left   = s_cur - {1'b0, sec_r} - SECT_W'(1);
  assign avail    = AVW'(s_left) * AVW'(eff_surf) + AVW'(eff_surf - SCW'(surf_r));
  assign take     = (COUNT_W'(avail) < count_r) ? COUNT_W'(avail) : count_r;
  assign trk_gap  = (head_r > trk_r) ? (head_r - trk_r) : (trk_r - head_r);
  assign rpm_s    = 29'(eff_rpm) * 29'(s_cur);
  assign off_w    = BASE_W'(addr_r) - base_r;

  // shared divider
  logic [DIV_W-1:0] dv_a, dv_b, dv_q, dv_r;
  logic             dv_done;

  always_comb begin
    unique case (cmd.div_sel)
      DV_CNT:  begin dv_a = DIV_W'(count_r);  dv_b = DIV_W'(eff_bytes); end
      DV_BLK:  begin dv_a = DIV_W'(addr_r);   dv_b = DIV_W'(eff_bytes); end
      DV_DIFF: begin dv_a = DIV_W'(eff_diff); dv_b = DIV_W'(d_trk);     end
      DV_OFF:  begin dv_a = DIV_W'(off_w);    dv_b = DIV_W'(eff_surf);  end
      DV_HALF: begin dv_a = PS_HALF_MIN;      dv_b = DIV_W'(eff_rpm);   end
      DV_SECT: begin dv_a = PS_MIN;           dv_b = DIV_W'(rpm_s);     end
      default: begin dv_a = '0;               dv_b = DIV_W'(1);         end
    endcase
  end

  zdat_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_go),
    .dividend  (dv_a),
    .divisor   (dv_b),
    .done      (dv_done),
    .quotient  (dv_q),
    .remainder (dv_r)
  );

  // shared multiplier
  logic [MUL_AW-1:0] mu_a;
  logic [MUL_BW-1:0] mu_b;
  logic [PROD_W-1:0] mu_p;
  logic              mu_done;
  logic [TIME_W-1:0] mu_sat;

  assign mu_a   = (cmd.mul_sel == MS_XFER) ? stime_r : MUL_AW'(cfg.seek_step_ps);
  assign mu_b   = (cmd.mul_sel == MS_XFER) ? take : MUL_BW'(trk_gap);
  assign mu_sat = sat_prod(mu_p);

  zdat_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_go),
    .a     (mu_a),
    .b     (mu_b),
    .done  (mu_done),
    .prod  (mu_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r <= in_data.start_time;
      addr_r  <= in_data.byte_address;
      count_r <= in_data.byte_count;
      base_r  <= '0;
      trk_r   <= '0;
      q_r     <= '0;
      rem_r   <= '0;
      ok_r    <= 1'b1;
      past_r  <= 1'b0;
    end
    if (cmd.div_take) begin
      unique case (cmd.div_sel)
        DV_CNT:  count_r <= dv_q[COUNT_W-1:0];
        DV_BLK:  addr_r  <= dv_q[ADDR_W-1:0];
        DV_DIFF: begin
          qd_r <= dv_q[11:0];
          rd_r <= dv_r[ETW-1:0];
        end
        DV_OFF: begin
          sec_r   <= dv_q[SECI_W-1:0];
          surf_r  <= dv_r[SIW-1:0];
          fsec_r  <= dv_q[SECI_W-1:0];
          fsurf_r <= dv_r[SIW-1:0];
          ftrk_r  <= trk_r;
        end
        DV_HALF: half_r  <= TIME_W'(dv_q);
        DV_SECT: stime_r <= dv_q;
        default: ;
      endcase
    end
    if (cmd.walk_adv || cmd.next_trk) begin
      trk_r <= trk_r + TW'(1);
      q_r   <= q_n;
      rem_r <= rem_n;
    end
    if (cmd.walk_adv) base_r <= base_sum;
    if (cmd.next_trk) begin
      sec_r  <= '0;
      surf_r <= '0;
    end
    if (cmd.set_bad) ok_r <= 1'b0;
    if (cmd.set_past) past_r <= 1'b1;
    if (cmd.hop_fix) hop_r <= sat_add(TIME_W'(cfg.seek_step_ps), TIME_W'(cfg.seek_fixed_ps));
    if (cmd.add_half) hop_r <= sat_add(hop_r, half_r);
    // running finish time
    if (cmd.clr_total) begin
      total_r <= '0;
    end else if (cmd.mul_take && cmd.mul_sel == MS_SEEK) begin
      total_r <= mu_sat;
    end else if (cmd.mul_take) begin
      total_r <= sat_add(total_r, mu_sat);
    end else if (cmd.add_fix) begin
      total_r <= sat_add(total_r, TIME_W'(cfg.seek_fixed_ps));
    end else if (cmd.add_half) begin
      total_r <= sat_add(total_r, half_r);
    end else if (cmd.next_trk) begin
      total_r <= sat_add(total_r, hop_r);
    end
    if (cmd.mul_take && cmd.mul_sel == MS_XFER) count_r <= count_r - take;
    if (cmd.finish) begin
      out_r.finish_time   <= ok_r ? sat_add(start_r, total_r) : start_r;
      out_r.address_ok    <= ok_r;
      out_r.past_end      <= ok_r & past_r;
      out_r.first_track   <= ok_r ? 16'(ftrk_r) : 16'd0;
      out_r.first_surface <= ok_r ? 4'(fsurf_r) : 4'd0;
      out_r.first_sector  <= ok_r ? fsec_r : 12'd0;
    end
  end

  // head position and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish && ok_r) head_r <= trk_r;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign sts.div_done  = dv_done;
  assign sts.mul_done  = mu_done;
  assign sts.found     = BASE_W'(addr_r) < base_sum;
  assign sts.last_trk  = trk_p1 == eff_tracks;
  assign sts.head_same = head_r == trk_r;
  assign sts.xfer_end  = count_r <= COUNT_W'(avail);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> src/zdat_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences decode, seek and per-track transfer steps.
module zdat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  zdat_pkg::zdat_sts_t sts,
  output zdat_pkg::zdat_cmd_t cmd
);

  import zdat_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CNT   = 4'd1;
  localparam logic [3:0] S_BLK   = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_OFF   = 4'd5;
  localparam logic [3:0] S_HALF  = 4'd6;
  localparam logic [3:0] S_SEEK  = 4'd7;
  localparam logic [3:0] S_FIX   = 4'd8;
  localparam logic [3:0] S_HADD  = 4'd9;
  localparam logic [3:0] S_SDIV  = 4'd10;
  localparam logic [3:0] S_SMUL  = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       run_r, run_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    run_nxt   = run_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CNT;
        end
      end
      S_CNT, S_BLK, S_DIFF, S_OFF, S_HALF, S_SDIV: begin
        unique case (state_r)
          S_CNT:   cmd.div_sel = DV_CNT;
          S_BLK:   cmd.div_sel = DV_BLK;
          S_DIFF:  cmd.div_sel = DV_DIFF;
          S_OFF:   cmd.div_sel = DV_OFF;
          S_HALF:  cmd.div_sel = DV_HALF;
          default: cmd.div_sel = DV_SECT;
        endcase
        if (!run_r) begin
          cmd.div_go = 1'b1;
          run_nxt    = 1'b1;
        end else if (sts.div_done) begin
          cmd.div_take = 1'b1;
          run_nxt      = 1'b0;
          unique case (state_r)
            S_CNT:   state_nxt = S_BLK;
            S_BLK:   state_nxt = S_DIFF;
            S_DIFF:  state_nxt = S_WALK;
            S_OFF:   state_nxt = S_HALF;
            S_HALF:  state_nxt = S_SEEK;
            default: state_nxt = S_SMUL;
          endcase
        end
      end
      S_WALK: begin
        if (sts.found) begin
          state_nxt = S_OFF;
        end else if (sts.last_trk) begin
          cmd.set_bad = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      S_SEEK: begin
        cmd.mul_sel = MS_SEEK;
        if (sts.head_same) begin
          cmd.clr_total = 1'b1;
          state_nxt     = S_FIX;
        end else if (!run_r) begin
          cmd.mul_go = 1'b1;
          run_nxt    = 1'b1;
        end else if (sts.mul_done) begin
          cmd.mul_take = 1'b1;
          run_nxt      = 1'b0;
          state_nxt    = S_FIX;
        end
      end
      S_FIX: begin
        cmd.hop_fix = 1'b1;
        cmd.add_fix = !sts.head_same;
        state_nxt   = S_HADD;
      end
      S_HADD: begin
        cmd.add_half = 1'b1;
        state_nxt    = S_SDIV;
      end
      S_SMUL: begin
        cmd.mul_sel = MS_XFER;
        if (!run_r) begin
          cmd.mul_go = 1'b1;
          run_nxt    = 1'b1;
        end else if (sts.mul_done) begin
          cmd.mul_take = 1'b1;
          run_nxt      = 1'b0;
          if (sts.xfer_end) begin
            state_nxt = S_DONE;
          end else if (sts.last_trk) begin
            cmd.set_past = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cmd.next_trk = 1'b1;
        state_nxt    = S_SDIV;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/zoned_disk_access_timer_unit.sv
`timescale 1ns / 1ps
// Top level of the zoned disk access timer.
//
// Maps a byte-addressed disk request onto a zoned layout (track, surface,
// sector; surface is the fast index) and returns the finish time in ps:
// start + seek from the current head track + half a revolution + per-sector
// transfer time, with a one-track seek and another half revolution for each
// further track. All times saturate at 2^63-1. One request is in work at a
// time; a new one is taken as soon as the previous result is written to the
// output register, even while that result still waits for its transfer.
// Work per request: five divides (sector count, block index, zone step,
// sector/surface split, half revolution), one walk step per track from
// track 0 to the addressed track, the seek multiply (skipped when the head
// is already there), and for each track touched by the transfer a divide
// for the sector time, a multiply and a track-change step. The track walk
// dominates for high addresses. All steps share one serial divider and
// one serial multiplier. Configuration must be written only while no
// request is in work; the block itself does not enforce this. cfg_ready
// is always high.
module zoned_disk_access_timer_unit #(
  parameter int MAX_TRACKS   = zdat_pkg::DEF_MAX_TRACKS,
  parameter int MAX_SURFACES = zdat_pkg::DEF_MAX_SURFACES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  zdat_pkg::zdat_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output zdat_pkg::zdat_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [zdat_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [zdat_pkg::CDAT_W-1:0]  cfg_data
);

  import zdat_pkg::*;

  zdat_cfg_t cfg;
  zdat_cmd_t cmd;
  zdat_sts_t sts;

  // register file; values are clamped to legal ranges in the datapath
  zdat_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: decode, track walk, seek, per-track transfer, result write
  zdat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds head track, running total and the output register
  zdat_dp #(
    .MAX_TRACKS   (MAX_TRACKS),
    .MAX_SURFACES (MAX_SURFACES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
